// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the top-k selector.
// Depends on nothing; expects clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset
`define TKS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next
`define TKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TKS_ASSERT_ALWAYS(lbl, expr)
`define TKS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/tks_pkg.sv
// Package of the top-k selector: field widths, beat types, cell control, states.
// No dependencies.
package tks_pkg;

  localparam int SizeW      = 48;
  localparam int TagW       = 16;
  localparam int KeepW      = 6;
  localparam int MaxKeepDef = 32;

  localparam logic [KeepW-1:0] KeepReset = 6'd20;

  // func field codes
  localparam logic FuncOffer  = 1'b0;
  localparam logic FuncFinish = 1'b1;

  typedef struct packed {
    logic            func;
    logic [SizeW-1:0] entry_size;
    logic [TagW-1:0]  entry_tag;
  } in_beat_t;

  typedef struct packed {
    logic             out_valid;
    logic [SizeW-1:0] out_size;
    logic [TagW-1:0]  out_tag;
    logic             out_last;
  } out_beat_t;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [TagW-1:0]  tag;
  } entry_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic   ins;        // insert new_entry into the sorted chain
    logic   drain;      // shift the chain one place toward the head
    entry_t new_entry;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_EMPTY
  } state_e;

endpackage

// File: src/top_k_largest_selector_core.sv
// Top-k selector: a chain of MAX_KEEP cells kept sorted by descending size.
// Offers are accepted one per cycle back to back while the block is idle.
// A finish stalls input for n result beats (one beat if empty); the first
// result appears the cycle after the finish, then one beat per cycle
// unless res_stall_i holds the result side.
// Reset (async, active low): store empty, keep_count 20, block idle.
`include "assert_macros.svh"
module top_k_largest_selector_core #(
  parameter int MAX_KEEP = tks_pkg::MaxKeepDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tks_pkg::KeepW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tks_pkg::in_beat_t           in_data_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output tks_pkg::out_beat_t          res_data_o
);

  localparam int CW   = $clog2(MAX_KEEP + 1);
  localparam int CmpW = (CW > tks_pkg::KeepW) ? CW : tks_pkg::KeepW;

  tks_pkg::state_e state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic [tks_pkg::KeepW-1:0]   keep_q;
  logic [CW-1:0]               k_eff;
  logic                        grow;
  logic                        in_acc, res_acc, is_finish;
  tks_pkg::cell_ctrl_t         ctrl;

  tks_pkg::entry_t             cell_entry [MAX_KEEP];
  tks_pkg::entry_t             cell_next  [MAX_KEEP];
  tks_pkg::entry_t             cell_prev  [MAX_KEEP];
  logic [MAX_KEEP:0]           ge_chain;
  logic [MAX_KEEP-1:0]         cell_valid;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign res_acc   = res_valid_o && !res_stall_i;
  assign is_finish = (in_data_i.func == tks_pkg::FuncFinish);

  // keep_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= tks_pkg::KeepReset;
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  // effective k, clamped to 1..MAX_KEEP
  always_comb begin
    if (keep_q == '0) begin
      k_eff = CW'(1);
    end else if (CmpW'(keep_q) > CmpW'(MAX_KEEP)) begin
      k_eff = CW'(MAX_KEEP);
    end else begin
      k_eff = CW'(keep_q);
    end
  end

  assign grow = (count_q < k_eff);

  // cell control broadcast
  always_comb begin
    ctrl.ins            = in_acc && !is_finish;
    ctrl.drain          = res_acc && (state_q == tks_pkg::ST_DRAIN);
    ctrl.new_entry.size = in_data_i.entry_size;
    ctrl.new_entry.tag  = in_data_i.entry_tag;
  end

  // the chain
  assign ge_chain[0] = 1'b1;
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    assign cell_valid[i] = (Idx < count_q);
    if (i == 0) begin : g_head
      assign cell_prev[i] = ctrl.new_entry;
    end else begin : g_body
      assign cell_prev[i] = cell_entry[i-1];
    end
    if (i == MAX_KEEP - 1) begin : g_tail
      assign cell_next[i] = cell_entry[i];
    end else begin : g_inner
      assign cell_next[i] = cell_entry[i+1];
    end
    tks_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (cell_valid[i]),
      .prev_ge_i    (ge_chain[i]),
      .prev_entry_i (cell_prev[i]),
      .next_entry_i (cell_next[i]),
      .entry_o      (cell_entry[i]),
      .ge_o         (ge_chain[i+1])
    );
  end

  // held count
  always_comb begin
    count_d = count_q;
    if (ctrl.ins && grow) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.drain) begin
      count_d = count_q - CW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tks_pkg::ST_IDLE: begin
        if (in_acc && is_finish) begin
          state_d = (count_q == '0) ? tks_pkg::ST_EMPTY : tks_pkg::ST_DRAIN;
        end
      end
      tks_pkg::ST_DRAIN: begin
        if (res_acc && (count_q == CW'(1))) begin
          state_d = tks_pkg::ST_IDLE;
        end
      end
      tks_pkg::ST_EMPTY: begin
        if (res_acc) begin
          state_d = tks_pkg::ST_IDLE;
        end
      end
      default: state_d = tks_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tks_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // outputs: head cell is the current result beat in drain, an empty marker beat in empty
  always_comb begin
    in_stall_o           = 1'b1;
    res_valid_o          = 1'b0;
    res_data_o.out_valid = 1'b1;
    res_data_o.out_size  = cell_entry[0].size;
    res_data_o.out_tag   = cell_entry[0].tag;
    res_data_o.out_last  = (count_q == CW'(1));
    case (state_q)
      tks_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      tks_pkg::ST_DRAIN: begin
        res_valid_o = 1'b1;
      end
      tks_pkg::ST_EMPTY: begin
        res_valid_o          = 1'b1;
        res_data_o.out_valid = 1'b0;
        res_data_o.out_size  = '0;
        res_data_o.out_tag   = '0;
        res_data_o.out_last  = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // checks
  `TKS_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(MAX_KEEP))
  `TKS_ASSERT_NEXT(a_grow_inc, ctrl.ins && grow, count_q == $past(count_q) + CW'(1))
  `TKS_ASSERT_NEXT(a_finish_res, in_acc && is_finish, res_valid_o && in_stall_o)
  `TKS_ASSERT_NEXT(a_last_idle, res_acc && res_data_o.out_last, !in_stall_o && count_q == '0)

endmodule

// File: src/tks_cell.sv
// One cell of the sorted chain: holds one entry, compares it to the offered one
// and loads the new entry or takes data from its upper or lower neighbor. Depends on tks_pkg.
module tks_cell (
  input  logic               clk_i,
  input  tks_pkg::cell_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  logic               prev_ge_i,
  input  tks_pkg::entry_t    prev_entry_i,
  input  tks_pkg::entry_t    next_entry_i,
  output tks_pkg::entry_t    entry_o,
  output logic               ge_o
);

  tks_pkg::entry_t entry_q, entry_d;

  // held entry stays ahead of the new one (ties keep arrival order)
  assign ge_o = valid_i && (entry_q.size >= ctrl_i.new_entry.size);

  // insert: first cell below the split loads the new entry, the rest shift down; drain takes the next entry
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !ge_o) begin
      entry_d = prev_ge_i ? ctrl_i.new_entry : prev_entry_i;
    end else if (ctrl_i.drain) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
